// File: rtl/text_full_justifier_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the text full justifier
// Concurrent checks clocked on clk_i. Each takes a label, a property and a
// message.
// ----------------------------------------------------------------------------
`ifndef TEXT_FULL_JUSTIFIER_DEFINES_SVH
`define TEXT_FULL_JUSTIFIER_DEFINES_SVH

// Check that is switched off while the reset is asserted.
`define TFJ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that also holds while the reset is asserted.
`define TFJ_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// File: rtl/tfj_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tfj_pkg
// Constants and types shared by the text full justifier.
// ----------------------------------------------------------------------------
package tfj_pkg;

  localparam int unsigned CH_W = 8;
  localparam int unsigned LW_W = 6;

  // Widest line and most words that a line can hold.
  localparam logic [LW_W-1:0] MAX_WIDTH      = 6'd32;
  localparam logic [4:0]      MAX_WORDS      = 5'd16;
  localparam logic [LW_W-1:0] LINE_WIDTH_RST = 6'd16;
  localparam logic [CH_W-1:0] SPACE_CHAR     = 8'd32;

  // Character buffer holds one line plus one pending word.
  localparam int unsigned BUF_DEPTH  = 64;
  localparam int unsigned BUF_AW     = 6;
  localparam int unsigned WL_DEPTH   = 16;
  localparam int unsigned WL_AW      = 4;
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_AW    = 2;

  typedef struct packed {
    logic [CH_W-1:0] ch;
    logic            line_end;
    logic            last;
  } out_item_t;

endpackage
`default_nettype wire

// File: rtl/text_full_justifier.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// text_full_justifier
// Greedy full justification of a character stream into fixed-width lines.
// ----------------------------------------------------------------------------
// Usage: word characters enter on the input channel (ch_i, word_end_i,
// text_end_i), one transaction per character. The output channel delivers
// one transaction per character of justified text, with line_end_o on the
// last character of each line and last_of_text_o on the last of the text.
// The line width is written through cfg_we_i/cfg_wdata_i while idle.
// Throughput: characters inside a word are taken at one per cycle. A word
// end that completes a line holds in_stall_o high while the line is read
// out of the character buffer: set-up, a division when spaces must be
// spread over the gaps, then one output character per cycle while the
// output queue has room, plus an append step for the word when a line was
// flushed first. Readout speed is set by the single read port of the
// character buffer. The first character of a line passes the set-up, the
// gap division if needed, the buffer read and the output queue.
// Reset: empty line, empty output queue, width 16. A stalled receiver only
// pauses readout, which keeps in_stall_o high longer; the output queue has 4 entries.
// ----------------------------------------------------------------------------
`include "text_full_justifier_defines.svh"

module text_full_justifier (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [tfj_pkg::LW_W-1:0]   cfg_wdata_i,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [tfj_pkg::CH_W-1:0]   ch_i,
  input  logic                       word_end_i,
  input  logic                       text_end_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [tfj_pkg::CH_W-1:0]   out_ch_o,
  output logic                       line_end_o,
  output logic                       last_of_text_o
);
  import tfj_pkg::*;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_DIV    = 3'd1;
  localparam logic [2:0] ST_WLD    = 3'd2;
  localparam logic [2:0] ST_SETUP  = 3'd3;
  localparam logic [2:0] ST_RUN    = 3'd4;
  localparam logic [2:0] ST_APPEND = 3'd5;

  localparam logic [1:0] MODE_CHAR = 2'd0;
  localparam logic [1:0] MODE_GAP  = 2'd1;
  localparam logic [1:0] MODE_PAD  = 2'd2;

  localparam logic [2:0] DIV_LAST  = 3'd5;
  localparam logic [FIFO_AW:0] FIFO_FULL = 3'd4;

  // Memories.
  logic [CH_W-1:0]  char_mem_q [BUF_DEPTH];
  logic [LW_W-1:0]  wl_mem_q   [WL_DEPTH];
  logic [CH_W-1:0]  cm_rdata_q;
  logic [LW_W-1:0]  wl_rdata_q;
  logic             cm_we, cm_re;
  logic [BUF_AW-1:0] cm_waddr;
  logic             wl_we, wl_re;
  logic [WL_AW-1:0] wl_waddr, wl_raddr;
  logic [LW_W-1:0]  wl_wdata;

  // Control state.
  logic [2:0]        state_q, state_d;
  logic [LW_W-1:0]   line_width_q;
  logic [BUF_AW-1:0] base_q, base_d;
  logic [LW_W-1:0]   chars_q, chars_d;
  logic [4:0]        words_q, words_d;
  logic [LW_W-1:0]   plen_q, plen_d;
  logic [LW_W-1:0]   len_q, len_d;
  logic              te_q, te_d;
  logic              after_q, after_d;
  logic              last_q, last_d;
  logic [LW_W-1:0]   dvd_q, dvd_d;
  logic [3:0]        rem_q, rem_d;
  logic [2:0]        step_q, step_d;
  logic [WL_AW-1:0]  j_q, j_d;
  logic [LW_W-1:0]   k_q, k_d;
  logic [LW_W-1:0]   sp_q, sp_d;
  logic [1:0]        mode_q, mode_d;
  logic [LW_W-1:0]   cnt_q, cnt_d;
  logic [BUF_AW-1:0] rd_ptr_q, rd_ptr_d;
  logic              s1_valid_q, s1_valid_d;
  logic              s1_sel_q, s1_sel_d;
  logic              s1_le_q, s1_le_d;
  logic              s1_lt_q, s1_lt_d;

  // Output queue.
  out_item_t          fifo_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0] fifo_wp_q, fifo_rp_q;
  logic [FIFO_AW:0]   fifo_cnt_q;
  logic               fifo_push, fifo_pop;
  out_item_t          push_item;

  // Datapath helpers.
  logic [LW_W-1:0] eff_w;
  logic            acc, eow, plen_lt, need_emit, div_go, room, run_issue, last_pos;
  logic [LW_W-1:0] plen_inc, wlen, total;
  logic [6:0]      fit_sum, gap_sum;
  logic [4:0]      gaps, j_next;
  logic [4:0]      div_r, div_diff;
  logic            div_ge;

  always_comb begin
    if (line_width_q == '0) begin
      eff_w = 6'd1;
    end else if (line_width_q > MAX_WIDTH) begin
      eff_w = MAX_WIDTH;
    end else begin
      eff_w = line_width_q;
    end
  end

  assign in_stall_o = (state_q != ST_IDLE);
  assign acc        = in_valid_i && !in_stall_o;
  assign eow        = word_end_i || text_end_i;
  assign plen_lt    = (plen_q < eff_w);
  assign plen_inc   = plen_q + {5'd0, plen_lt};
  assign wlen       = (plen_inc < eff_w) ? plen_inc : eff_w;
  assign fit_sum    = {1'b0, chars_q} + {1'b0, wlen} + {2'b00, words_q};
  assign need_emit  = (words_q != 5'd0) &&
                      ((fit_sum > {1'b0, eff_w}) || (words_q >= MAX_WORDS));
  assign gaps       = words_q - 5'd1;
  assign gap_sum    = {1'b0, chars_q} + {2'b00, gaps};
  assign div_go     = (gaps != 5'd0) && (gap_sum <= {1'b0, eff_w});
  assign total      = eff_w - chars_q;
  assign j_next     = {1'b0, j_q} + 5'd1;

  // One quotient bit per cycle: total spaces over the number of gaps.
  assign div_r    = {rem_q, dvd_q[LW_W-1]};
  assign div_ge   = (div_r >= {1'b0, gaps[3:0]});
  assign div_diff = div_r - {1'b0, gaps[3:0]};

  assign room      = ({1'b0, fifo_cnt_q} + {3'b000, s1_valid_q}) < {1'b0, FIFO_FULL};
  assign run_issue = (state_q == ST_RUN) && room;
  assign last_pos  = (cnt_q == (eff_w - 6'd1));

  assign cm_we    = acc && plen_lt;
  assign cm_waddr = base_q + chars_q + plen_q;
  assign cm_re    = run_issue && (mode_q == MODE_CHAR);
  assign wl_we    = (acc && eow && !need_emit) || (state_q == ST_APPEND);
  assign wl_waddr = words_q[WL_AW-1:0];
  assign wl_wdata = (state_q == ST_APPEND) ? len_q : wlen;

  always_comb begin
    state_d    = state_q;
    base_d     = base_q;
    chars_d    = chars_q;
    words_d    = words_q;
    plen_d     = plen_q;
    len_d      = len_q;
    te_d       = te_q;
    after_d    = after_q;
    last_d     = last_q;
    dvd_d      = dvd_q;
    rem_d      = rem_q;
    step_d     = step_q;
    j_d        = j_q;
    k_d        = k_q;
    sp_d       = sp_q;
    mode_d     = mode_q;
    cnt_d      = cnt_q;
    rd_ptr_d   = rd_ptr_q;
    s1_valid_d = 1'b0;
    s1_sel_d   = s1_sel_q;
    s1_le_d    = s1_le_q;
    s1_lt_d    = s1_lt_q;
    wl_re      = 1'b0;
    wl_raddr   = j_q;

    case (state_q)
      ST_IDLE: begin
        if (acc) begin
          plen_d = plen_inc;
          if (eow) begin
            plen_d   = '0;
            j_d      = '0;
            cnt_d    = '0;
            rd_ptr_d = base_q;
            rem_d    = '0;
            step_d   = '0;
            if (need_emit) begin
              // Flush the current line first; the word is appended after it.
              len_d   = wlen;
              te_d    = text_end_i;
              after_d = 1'b1;
              last_d  = 1'b0;
              if (div_go) begin
                dvd_d   = total;
                state_d = ST_DIV;
              end else begin
                dvd_d   = 6'd1;
                state_d = ST_WLD;
              end
            end else begin
              words_d = words_q + 5'd1;
              chars_d = chars_q + wlen;
              after_d = 1'b0;
              last_d  = 1'b1;
              dvd_d   = 6'd1;
              if (text_end_i) begin
                state_d = ST_WLD;
              end
            end
          end
        end
      end
      ST_DIV: begin
        rem_d  = div_ge ? div_diff[3:0] : div_r[3:0];
        dvd_d  = {dvd_q[LW_W-2:0], div_ge};
        step_d = step_q + 3'd1;
        if (step_q == DIV_LAST) begin
          state_d = ST_WLD;
        end
      end
      ST_WLD: begin
        wl_re    = 1'b1;
        wl_raddr = j_q;
        state_d  = ST_SETUP;
      end
      ST_SETUP: begin
        k_d      = wl_rdata_q;
        mode_d   = MODE_CHAR;
        wl_re    = 1'b1;
        wl_raddr = j_next[WL_AW-1:0];
        state_d  = ST_RUN;
      end
      ST_RUN: begin
        if (run_issue) begin
          s1_valid_d = 1'b1;
          s1_sel_d   = (mode_q == MODE_CHAR);
          s1_le_d    = last_pos;
          s1_lt_d    = last_pos && last_q;
          cnt_d      = cnt_q + 6'd1;
          case (mode_q)
            MODE_CHAR: begin
              rd_ptr_d = rd_ptr_q + 6'd1;
              k_d      = k_q - 6'd1;
              if (k_q == 6'd1) begin
                if (j_next < words_q) begin
                  mode_d = MODE_GAP;
                  sp_d   = dvd_q + {5'd0, (j_q < rem_q)};
                end else begin
                  mode_d = MODE_PAD;
                end
              end
            end
            MODE_GAP: begin
              if (sp_q == 6'd1) begin
                mode_d   = MODE_CHAR;
                j_d      = j_next[WL_AW-1:0];
                k_d      = wl_rdata_q;
                wl_re    = 1'b1;
                wl_raddr = j_q + 4'd2;
              end else begin
                sp_d = sp_q - 6'd1;
              end
            end
            default: begin
            end
          endcase
          if (last_pos) begin
            base_d  = base_q + chars_q;
            words_d = '0;
            chars_d = '0;
            state_d = after_q ? ST_APPEND : ST_IDLE;
          end
        end
      end
      ST_APPEND: begin
        words_d  = 5'd1;
        chars_d  = len_q;
        after_d  = 1'b0;
        last_d   = 1'b1;
        j_d      = '0;
        cnt_d    = '0;
        rd_ptr_d = base_q;
        dvd_d    = 6'd1;
        rem_d    = '0;
        state_d  = te_q ? ST_WLD : ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      line_width_q <= LINE_WIDTH_RST;
      base_q       <= '0;
      chars_q      <= '0;
      words_q      <= '0;
      plen_q       <= '0;
      len_q        <= '0;
      te_q         <= 1'b0;
      after_q      <= 1'b0;
      last_q       <= 1'b0;
      dvd_q        <= '0;
      rem_q        <= '0;
      step_q       <= '0;
      j_q          <= '0;
      k_q          <= '0;
      sp_q         <= '0;
      mode_q       <= MODE_CHAR;
      cnt_q        <= '0;
      rd_ptr_q     <= '0;
      s1_valid_q   <= 1'b0;
      s1_sel_q     <= 1'b0;
      s1_le_q      <= 1'b0;
      s1_lt_q      <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        line_width_q <= cfg_wdata_i;
      end
      state_q    <= state_d;
      base_q     <= base_d;
      chars_q    <= chars_d;
      words_q    <= words_d;
      plen_q     <= plen_d;
      len_q      <= len_d;
      te_q       <= te_d;
      after_q    <= after_d;
      last_q     <= last_d;
      dvd_q      <= dvd_d;
      rem_q      <= rem_d;
      step_q     <= step_d;
      j_q        <= j_d;
      k_q        <= k_d;
      sp_q       <= sp_d;
      mode_q     <= mode_d;
      cnt_q      <= cnt_d;
      rd_ptr_q   <= rd_ptr_d;
      s1_valid_q <= s1_valid_d;
      s1_sel_q   <= s1_sel_d;
      s1_le_q    <= s1_le_d;
      s1_lt_q    <= s1_lt_d;
    end
  end

  // The line sits at base_q and the pending word right behind it, so a word
  // that fits never has to be moved.
  always_ff @(posedge clk_i) begin
    if (cm_we) begin
      char_mem_q[cm_waddr] <= ch_i;
    end
    if (cm_re) begin
      cm_rdata_q <= char_mem_q[rd_ptr_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (wl_we) begin
      wl_mem_q[wl_waddr] <= wl_wdata;
    end
    if (wl_re) begin
      wl_rdata_q <= wl_mem_q[wl_raddr];
    end
  end

  // Output queue: an item enters in the cycle after its issue, once the
  // character read has returned.
  assign fifo_push          = s1_valid_q;
  assign fifo_pop           = out_valid_o && !out_stall_i;
  assign push_item.ch       = s1_sel_q ? cm_rdata_q : SPACE_CHAR;
  assign push_item.line_end = s1_le_q;
  assign push_item.last     = s1_lt_q;

  always_ff @(posedge clk_i) begin
    if (fifo_push) begin
      fifo_q[fifo_wp_q] <= push_item;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fifo_wp_q  <= '0;
      fifo_rp_q  <= '0;
      fifo_cnt_q <= '0;
    end else begin
      if (fifo_push) begin
        fifo_wp_q <= fifo_wp_q + 2'd1;
      end
      if (fifo_pop) begin
        fifo_rp_q <= fifo_rp_q + 2'd1;
      end
      fifo_cnt_q <= fifo_cnt_q + {2'b00, fifo_push} - {2'b00, fifo_pop};
    end
  end

  assign out_valid_o    = (fifo_cnt_q != '0);
  assign out_ch_o       = fifo_q[fifo_rp_q].ch;
  assign line_end_o     = fifo_q[fifo_rp_q].line_end;
  assign last_of_text_o = fifo_q[fifo_rp_q].last;

  `TFJ_ASSERT(a_fifo_no_overflow, (fifo_push && (fifo_cnt_q == FIFO_FULL)) |-> fifo_pop, "output queue overflow")
  `TFJ_ASSERT(a_char_mode_has_chars, ((state_q == ST_RUN) && (mode_q == MODE_CHAR)) |-> (k_q != 6'd0), "character mode with empty word")
  `TFJ_ASSERT(a_line_bounds, (chars_q <= MAX_WIDTH) && (words_q <= MAX_WORDS), "line buffer over its limits")
  `TFJ_ASSERT(a_line_cleared, (run_issue && last_pos) |=> (words_q == 5'd0) && (chars_q == 6'd0), "line not cleared after readout")
  `TFJ_ASSERT_ALWAYS(a_reset_quiet, !rst_ni |=> (!out_valid_o && !in_stall_o), "block busy in reset")

endmodule
`default_nettype wire
